FILE: rtl/nltsc_pkg.sv
// ---------------------------------------------------------------------------
// nltsc_pkg
// Shared types and constants for the length-prefix to start-code converter.
// ---------------------------------------------------------------------------
package nltsc_pkg;

    localparam int PREFIX_BYTES = 4;
    localparam logic [1:0] HDR_LAST = 2'(PREFIX_BYTES - 1);

    localparam int QUEUE_DEPTH = 8;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] ST_DATA         = 2'd0;
    localparam logic [1:0] ST_SHORT_HEADER = 2'd1;
    localparam logic [1:0] ST_TOO_LONG     = 2'd2;

    localparam logic [1:0] SC_LAST_STEP = 2'd3;
    localparam logic [7:0] SC_ONE       = 8'h01;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_PAYLOAD = 3'b010,
        PH_DROP    = 3'b100
    } phase_t;

    typedef enum logic [1:0] {
        CMD_DATA  = 2'd0,
        CMD_START = 2'd1,
        CMD_SHORT = 2'd2,
        CMD_LONG  = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        logic [7:0]  in_byte;
        logic        first_of_packet;
        logic [23:0] packet_bytes;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       last_of_run;
        logic       unit_end;
    } out_word_t;

    // flag: unit end on a data byte, empty unit on a start code
    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;
        logic       flag;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_head_t;

endpackage

FILE: rtl/nal_length_to_start_code.sv
// ---------------------------------------------------------------------------
// nal_length_to_start_code
// Converts length-prefixed NAL unit packets into a start-code byte stream.
// ---------------------------------------------------------------------------
//  channel  | signals                        | word
//  ---------+--------------------------------+-------------------------------
//  pkt      | pkt_valid, pkt_ready, pkt_data | in_byte, first_of_packet,
//           |                                | packet_bytes
//  es       | es_valid, es_ready, es_data    | out_byte, status, last_of_run,
//           |                                | unit_end
//
//  one packet byte accepted per cycle unless a full queue drops pkt_ready;
//  the output sequencer gives one word per cycle, its output register held
//  while es_ready is low; a start code gives 00 00 00 01, absorbed by the
//  8-entry queue while the next header's bytes arrive. a byte passes the
//  queue head and output registers. reset clears parser, queue pointers, es_valid.
// ---------------------------------------------------------------------------
module nal_length_to_start_code #(
    parameter int PACKET_COUNT_BITS = 24
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pkt_valid,
    output logic                 pkt_ready,
    input  nltsc_pkg::in_word_t  pkt_data,
    output logic                 es_valid,
    input  logic                 es_ready,
    output nltsc_pkg::out_word_t es_data
);

    logic               accept;
    logic               push;
    logic               pop;
    logic               full;
    nltsc_pkg::cmd_t    cmd;
    nltsc_pkg::q_head_t head;

    assign pkt_ready = !full;
    assign accept    = pkt_valid && pkt_ready;

    nltsc_front #(
        .PACKET_COUNT_BITS(PACKET_COUNT_BITS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .word   (pkt_data),
        .push   (push),
        .cmd    (cmd)
    );

    nltsc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (cmd),
        .pop      (pop),
        .full     (full),
        .head     (head)
    );

    nltsc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .pop      (pop),
        .es_valid (es_valid),
        .es_ready (es_ready),
        .es_data  (es_data)
    );

endmodule

FILE: rtl/nltsc_front.sv
// ---------------------------------------------------------------------------
// nltsc_front
// Packet parser: collects length headers, checks them and issues commands.
// ---------------------------------------------------------------------------
module nltsc_front #(
    parameter int PACKET_COUNT_BITS = 24
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  nltsc_pkg::in_word_t word,
    output logic              push,
    output nltsc_pkg::cmd_t   cmd
);

    localparam int PCB = PACKET_COUNT_BITS;

    nltsc_pkg::phase_t phase_reg, phase_next, phase_cur;
    logic [1:0]     hc_reg, hc_next, hc_cur;
    logic [31:0]    acc_reg, acc_next, acc_cur, acc_shift;
    logic [PCB-1:0] pl_reg, pl_next, pl_cur, pl_dec, pb_masked;
    logic [PCB-1:0] payl_reg, payl_next, payl_dec;
    logic           first;

    assign first     = word.first_of_packet;
    assign pb_masked = PCB'(word.packet_bytes);
    assign phase_cur = first ? nltsc_pkg::PH_HEADER : phase_reg;
    assign hc_cur    = first ? 2'd0 : hc_reg;
    assign acc_cur   = first ? 32'd0 : acc_reg;
    assign pl_cur    = first ? pb_masked : pl_reg;
    assign pl_dec    = pl_cur - PCB'(1);
    assign payl_dec  = payl_reg - PCB'(1);
    assign acc_shift = {acc_cur[23:0], word.in_byte};

    always_comb
    begin
        phase_next = phase_reg;
        hc_next    = hc_reg;
        acc_next   = acc_reg;
        pl_next    = pl_reg;
        payl_next  = payl_reg;
        push       = 1'b0;
        cmd.kind   = nltsc_pkg::CMD_DATA;
        cmd.data   = word.in_byte;
        cmd.flag   = 1'b0;
        if (accept)
        begin
            if (first)
            begin
                phase_next = nltsc_pkg::PH_HEADER;
                hc_next    = 2'd0;
                acc_next   = 32'd0;
                payl_next  = '0;
                pl_next    = pb_masked;
            end
            // no packet open: byte is ignored
            if (pl_cur != '0)
            begin
                pl_next = pl_dec;
                case (phase_cur)
                    nltsc_pkg::PH_PAYLOAD:
                    begin
                        payl_next = payl_dec;
                        push      = 1'b1;
                        cmd.flag  = (payl_dec == '0);
                        if (payl_dec == '0)
                        begin
                            phase_next = nltsc_pkg::PH_HEADER;
                            hc_next    = 2'd0;
                            acc_next   = 32'd0;
                        end
                    end
                    nltsc_pkg::PH_HEADER:
                    begin
                        if (hc_cur != nltsc_pkg::HDR_LAST)
                        begin
                            hc_next  = hc_cur + 2'd1;
                            acc_next = acc_shift;
                            if (pl_dec == '0)
                            begin
                                phase_next = nltsc_pkg::PH_DROP;
                                push       = 1'b1;
                                cmd.kind   = nltsc_pkg::CMD_SHORT;
                            end
                        end
                        else if (acc_shift > 32'(pl_dec))
                        begin
                            phase_next = nltsc_pkg::PH_DROP;
                            hc_next    = 2'd0;
                            acc_next   = acc_shift;
                            push       = 1'b1;
                            cmd.kind   = nltsc_pkg::CMD_LONG;
                        end
                        else
                        begin
                            push     = 1'b1;
                            cmd.kind = nltsc_pkg::CMD_START;
                            cmd.flag = (acc_shift == 32'd0);
                            hc_next  = 2'd0;
                            acc_next = 32'd0;
                            if (acc_shift == 32'd0)
                                phase_next = nltsc_pkg::PH_HEADER;
                            else
                            begin
                                phase_next = nltsc_pkg::PH_PAYLOAD;
                                payl_next  = PCB'(acc_shift);
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= nltsc_pkg::PH_HEADER;
            hc_reg    <= 2'd0;
            acc_reg   <= 32'd0;
            pl_reg    <= '0;
            payl_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            hc_reg    <= hc_next;
            acc_reg   <= acc_next;
            pl_reg    <= pl_next;
            payl_reg  <= payl_next;
        end
    end

endmodule

FILE: rtl/nltsc_queue.sv
// ---------------------------------------------------------------------------
// nltsc_queue
// Short command queue between parser and output sequencer.
// ---------------------------------------------------------------------------
module nltsc_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  nltsc_pkg::cmd_t    push_cmd,
    input  logic               pop,
    output logic               full,
    output nltsc_pkg::q_head_t head
);

    localparam int AW = nltsc_pkg::QUEUE_AW;

    nltsc_pkg::cmd_t mem_reg [nltsc_pkg::QUEUE_DEPTH];
    nltsc_pkg::cmd_t head_cmd_reg;
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [AW:0]     count_reg, count_next;
    logic            do_pop;

    assign full       = (count_reg == (AW+1)'(nltsc_pkg::QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.cmd   = head_cmd_reg;
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + (push ? AW'(1) : AW'(0));
        rd_ptr_next = rd_ptr_reg + (do_pop ? AW'(1) : AW'(0));
        count_next  = count_reg + (push ? (AW+1)'(1) : '0) - (do_pop ? (AW+1)'(1) : '0);
    end

    // head word read ahead at the next read address, bypassing a same-edge write
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cmd;
        if (push && (wr_ptr_reg == rd_ptr_next))
            head_cmd_reg <= push_cmd;
        else
            head_cmd_reg <= mem_reg[rd_ptr_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/nltsc_back.sv
// ---------------------------------------------------------------------------
// nltsc_back
// Output sequencer: expands commands into result words, one per cycle while es_ready does not stall it.
// ---------------------------------------------------------------------------
module nltsc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  nltsc_pkg::q_head_t   head,
    output logic                 pop,
    output logic                 es_valid,
    input  logic                 es_ready,
    output nltsc_pkg::out_word_t es_data
);

    logic                 out_valid_reg, out_valid_next;
    nltsc_pkg::out_word_t out_reg, out_next;
    logic [1:0]           step_reg, step_next;
    logic                 load;

    assign load     = !out_valid_reg || es_ready;
    assign es_valid = out_valid_reg;
    assign es_data  = out_reg;

    always_comb
    begin
        out_valid_next       = out_valid_reg && !es_ready;
        out_next             = out_reg;
        step_next            = step_reg;
        pop                  = 1'b0;
        if (load && head.valid)
        begin
            out_valid_next       = 1'b1;
            out_next.out_byte    = 8'd0;
            out_next.status      = nltsc_pkg::ST_DATA;
            out_next.last_of_run = 1'b1;
            out_next.unit_end    = 1'b0;
            pop                  = 1'b1;
            case (head.cmd.kind)
                nltsc_pkg::CMD_DATA:
                begin
                    out_next.out_byte = head.cmd.data;
                    out_next.unit_end = head.cmd.flag;
                end
                nltsc_pkg::CMD_START:
                begin
                    // three zero bytes then 01, command held until the last
                    if (step_reg == nltsc_pkg::SC_LAST_STEP)
                    begin
                        out_next.out_byte = nltsc_pkg::SC_ONE;
                        out_next.unit_end = head.cmd.flag;
                        step_next         = 2'd0;
                    end
                    else
                    begin
                        out_next.last_of_run = 1'b0;
                        step_next            = step_reg + 2'd1;
                        pop                  = 1'b0;
                    end
                end
                nltsc_pkg::CMD_SHORT:
                    out_next.status = nltsc_pkg::ST_SHORT_HEADER;
                nltsc_pkg::CMD_LONG:
                    out_next.status = nltsc_pkg::ST_TOO_LONG;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            step_reg      <= 2'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
        end
    end

endmodule
